// ===== rtl/apd_pkg.sv =====
// Package for the ADC packet deframer: frame constants, status codes and
// register map. No dependencies.
`timescale 1ns / 1ps

package apd_pkg;

  // Frame layout: byte 0 is sync, bytes 1..8 payload, byte 9 checksum
  localparam int unsigned PAYLOAD_LEN = 8;
  localparam int unsigned CHAN_COUNT  = 4;
  localparam logic [3:0]  LAST_POS    = 4'd9;
  localparam logic [3:0]  IDLE_POS    = 4'd10;

  // Register map (byte addresses 4*index)
  localparam int unsigned ADDR_W      = 3;
  localparam logic        REG_HEADER  = 1'b0;
  localparam logic [7:0]  HEADER_RESET = 8'hAA;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    STAT_OK           = 2'd0,
    STAT_BAD_HEADER   = 2'd1,
    STAT_BAD_CHECKSUM = 2'd2
  } status_t;

endpackage

// ===== rtl/adc_packet_deframer_unit.sv =====
// ADC packet deframer top level: frame tracking, checksum and result register.
// Depends on apd_pkg.
`timescale 1ns / 1ps
//
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata[7:0] rx_byte, tuser[0] frame_start
// m_axis    out  tvalid/tready          tdata 4 x 16-bit channels, tuser status
// apb       in   psel/penable/pready    header_value at byte address 0
//
// One byte is taken per cycle while the input is ready; a result appears in the cycle after the checksum
// byte is taken and is held in a single output register until taken.
// The input is ready whenever that register is empty or is being drained.
// Reset (synchronous) idles the frame tracker and loads header_value = 0xAA.
// A stalled result blocks new bytes only while it cannot be drained.

module adc_packet_deframer_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
  input  logic                        s_axis_tuser,   // [0] frame_start
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [63:0]                 m_axis_tdata,   // [15:0] ch0 .. [63:48] ch3
  output logic [1:0]                  m_axis_tuser,   // [1:0] frame_status
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [apd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import apd_pkg::*;

  byte_t       header_value;
  logic [3:0]  byte_position;
  byte_t       running_parity;
  logic        header_matched;
  byte_t       payload_bytes [PAYLOAD_LEN];

  logic        in_fire;
  logic        out_fire;
  logic        in_frame;
  logic        last_byte;
  status_t     status_next;
  logic [63:0] data_next;
  logic        reg_sel;

  // Config port: writes complete in the access phase
  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1] == REG_HEADER);
  assign prdata  = reg_sel ? {24'd0, header_value} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= HEADER_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      header_value <= pwdata[7:0];
    end
  end

  // Handshakes
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  assign in_frame  = (byte_position != 4'd0) && (byte_position < IDLE_POS);
  assign last_byte = !s_axis_tuser && in_frame && (byte_position == LAST_POS);

  // Decide the status and assemble the channels for the checksum byte
  always_comb begin
    if (!header_matched) begin
      status_next = STAT_BAD_HEADER;
    end else if (s_axis_tdata != running_parity) begin
      status_next = STAT_BAD_CHECKSUM;
    end else begin
      status_next = STAT_OK;
    end
    data_next = 64'd0;
    if (status_next == STAT_OK) begin
      for (int k = 0; k < CHAN_COUNT; k++) begin
        data_next[16*k +: 16] = {payload_bytes[2*k+1], payload_bytes[2*k]};
      end
    end
  end

  // Frame tracker: restart on start flag, advance within a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= IDLE_POS;
      running_parity <= 8'd0;
      header_matched <= 1'b0;
    end else if (in_fire) begin
      if (s_axis_tuser) begin
        byte_position  <= 4'd1;
        running_parity <= s_axis_tdata;
        header_matched <= (s_axis_tdata == header_value);
      end else if (in_frame) begin
        if (byte_position == LAST_POS) begin
          byte_position <= IDLE_POS;
        end else begin
          byte_position  <= byte_position + 4'd1;
          running_parity <= running_parity ^ s_axis_tdata;
        end
      end
    end
  end

  // Hold payload bytes 1..8 at their frame slot
  always_ff @(posedge clk) begin
    if (in_fire && !s_axis_tuser && in_frame && (byte_position != LAST_POS)) begin
      payload_bytes[3'(byte_position - 4'd1)] <= s_axis_tdata;
    end
  end

  // Result register: load on the checksum byte, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire && last_byte) begin
      m_axis_tvalid <= 1'b1;
    end else if (out_fire) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last_byte) begin
      m_axis_tdata <= data_next;
      m_axis_tuser <= status_next;
    end
  end

  // Checks
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (byte_position >= 4'd1) && (byte_position <= IDLE_POS))
    else $error("byte position out of range");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(in_fire && last_byte))
    else $error("result without a checksum word");

  a_error_zeroes: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> (m_axis_tdata == 64'd0))
    else $error("channels not cleared on a bad frame");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("undefined status code");

endmodule
